// File: design/sha0_pkg.sv
// SHA-0 digest package: constants, initial vector and shared types.
// No dependencies; used by every other design file except the checker.
package sha0_pkg;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [159:0] IV = 160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;
	localparam int QDEPTH = 4;

	// one input item, also passed from front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last_byte;
	} cmd_t;

	typedef struct packed {
		logic [63:0] digest_high;
		logic [63:0] digest_mid;
		logic [31:0] digest_low;
	} digest_t;
endpackage

// File: design/sha0_if.sv
// Valid/ready stream interfaces with source and sink modports.
// Depends on sha0_pkg for the payload types.
interface sha0_in_if;
	logic           valid;
	logic           ready;
	sha0_pkg::cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sha0_out_if;
	logic              valid;
	logic              ready;
	sha0_pkg::digest_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/sha0_front.sv
// Front part: accepts input items and holds them in a short queue.
// Depends on sha0_pkg.
module sha0_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_data,
	input  logic              in_has_byte,
	input  logic              in_last,
	input  logic              in_valid,
	output logic              in_ready,
	output sha0_pkg::cmd_t    q_cmd,
	output logic              q_valid,
	input  logic              q_ready
);
	localparam int AW = $clog2(sha0_pkg::QDEPTH);
	sha0_pkg::cmd_t mem_q [sha0_pkg::QDEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != (AW+1)'(sha0_pkg::QDEPTH));
	// drop items that carry neither a byte nor an end mark
	assign push = in_valid && in_ready && (in_has_byte || in_last);
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_ready;
	assign q_cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= '{data_byte: in_data, byte_valid: in_has_byte, last_byte: in_last};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

// File: design/sha0_back.sv
// Back part: packs bytes into blocks, pads, runs 80 rounds one per cycle.
// Depends on sha0_pkg.
module sha0_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sha0_pkg::cmd_t    q_cmd,
	input  logic              q_valid,
	output logic              q_ready,
	output sha0_pkg::digest_t dig,
	output logic              dig_valid,
	input  logic              dig_ready
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_PAD  = 5'b00010,
		S_RUN  = 5'b00100,
		S_ADD  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic [31:0] w_q [16];
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [6:0]  rnd_q;
	logic [5:0]  pos_q;
	logic [63:0] total_q;
	logic [63:0] bits_q;
	logic        fin_q;
	logic        lenw_q;
	// set while padding must resume after the current compression
	logic        pending_pad_q;

	logic [31:0] f, k, t, wnew;
	logic [7:0]  pad_byte;
	logic        take;

	assign q_ready = (state_q == S_IDLE);
	assign take = q_valid && q_ready;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = sha0_pkg::K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = sha0_pkg::K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = sha0_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q; k = sha0_pkg::K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		// schedule word 16 ahead, no rotation
		wnew = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	end

	// pad byte at current offset: zeros, then length
	always_comb begin
		if (!lenw_q) pad_byte = 8'h00;
		else pad_byte = bits_q[63:56];
	end

	assign dig = '{digest_high: {h_q[0], h_q[1]}, digest_mid: {h_q[2], h_q[3]},
		digest_low: h_q[4]};
	assign dig_valid = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			bits_q <= '0;
			pos_q <= '0;
			fin_q <= 1'b0;
			lenw_q <= 1'b0;
			rnd_q <= '0;
			for (int i = 0; i < 16; i++) w_q[i] <= '0;
			for (int i = 0; i < 5; i++) h_q[i] <= sha0_pkg::IV[159-32*i -: 32];
		end else begin
			unique case (state_q)
				S_IDLE: if (take) begin
					if (q_cmd.byte_valid) begin
						w_q[pos_q[5:2]] <= {w_q[pos_q[5:2]][23:0], q_cmd.data_byte};
						pos_q <= pos_q + 1'b1;
						total_q <= total_q + 64'd1;
					end
					if (q_cmd.last_byte) begin
						bits_q <= (total_q + 64'(q_cmd.byte_valid)) << 3;
						fin_q <= 1'b1;
						lenw_q <= 1'b0;
					end
					if (q_cmd.byte_valid && pos_q == 6'd63) begin
						state_q <= S_RUN;
					end else if (q_cmd.last_byte) begin
						state_q <= S_PAD;
					end
					// 0x80 goes in on the first pad cycle via fin flag
				end
				S_PAD: begin
					if (fin_q) begin
						w_q[pos_q[5:2]] <= {w_q[pos_q[5:2]][23:0], sha0_pkg::PAD_BYTE};
						fin_q <= 1'b0;
					end else begin
						w_q[pos_q[5:2]] <= {w_q[pos_q[5:2]][23:0], pad_byte};
						if (lenw_q) bits_q <= {bits_q[55:0], 8'h00};
					end
					pos_q <= pos_q + 1'b1;
					if (pos_q + 6'd1 == sha0_pkg::LEN_OFFSET) lenw_q <= 1'b1;
					if (pos_q == 6'd63) state_q <= S_RUN;
				end
				S_RUN: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wnew;
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 7'd79) state_q <= S_ADD;
				end
				S_ADD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					rnd_q <= '0;
					// after a length block the message is done
					if (lenw_q) state_q <= S_OUT;
					else if (pending_pad_q) state_q <= S_PAD;
					else state_q <= S_IDLE;
				end
				S_OUT: if (dig_ready) begin
					for (int i = 0; i < 5; i++) h_q[i] <= sha0_pkg::IV[159-32*i -: 32];
					total_q <= '0;
					pos_q <= '0;
					lenw_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pending_pad_q <= 1'b0;
		else if (take) pending_pad_q <= q_cmd.last_byte;
		else if (state_q == S_OUT) pending_pad_q <= 1'b0;
	end

	// load working words before each compression, then run the rounds
	always_ff @(posedge clk) begin
		if (state_q != S_RUN) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
		end else begin
			e_q <= d_q; d_q <= c_q; c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q; a_q <= t;
		end
	end
endmodule

// File: design/sha0_message_digest.sv
// Top level of the SHA-0 digest block: front queue and compression back end.
// Depends on sha0_pkg, sha0_if, sha0_front and sha0_back.
//
//  channel  dir  payload                               accepted when
//  in_ch    in   data_byte, byte_valid, last_byte      valid && ready
//  out_ch   out  digest_high, digest_mid, digest_low   valid && ready
//
// Bytes are taken while the back end is idle; every 64th byte starts a compression
// of 80 rounds in one round unit plus the add, during which no byte is taken.
// An end item adds padding at one byte a cycle, one or two compressions
// and the digest, held until taken. Reset loads the initial vector.
// The four-entry queue keeps taking items, until it is full, while the back end
// compresses or the digest waits.
module sha0_message_digest (
	input logic clk,
	input logic arst_n,
	sha0_in_if.sink    in_ch,
	sha0_out_if.source out_ch
);
	sha0_pkg::cmd_t q_cmd;
	logic q_valid, q_ready;

	sha0_front u_front (
		.clk, .arst_n,
		.in_data(in_ch.data.data_byte), .in_has_byte(in_ch.data.byte_valid),
		.in_last(in_ch.data.last_byte), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.q_cmd, .q_valid, .q_ready
	);

	sha0_back u_back (
		.clk, .arst_n, .q_cmd, .q_valid, .q_ready,
		.dig(out_ch.data), .dig_valid(out_ch.valid), .dig_ready(out_ch.ready)
	);
endmodule

// File: design/sha0_checker.sv
// Port-level checker for the SHA-0 digest block, bound to the top level.
// Depends on sha0_message_digest ports only.
module sha0_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [63:0] digest_high
);
	// a digest waiting stays valid, with its high half stable, until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_high))
		else $error("digest dropped or changed while stalled");
	// valid drops in the cycle after the digest is taken
	a_out_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("digest repeated");
	a_rst_ready: assert property (@(posedge clk) $rose(arst_n) |-> in_ready && !out_valid)
		else $error("not ready after reset");
endmodule

bind sha0_message_digest sha0_checker u_chk (
	.clk, .arst_n,
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.digest_high(out_ch.data.digest_high)
);
